FILE: rtl/gwwp_pkg.sv
// ----------------------------------------------------------------------------
// gwwp_pkg: types and constants of the greedy word wrap pager
// Holds the input and output word types, the layout state record and the
// field codes that the pager uses.
// ----------------------------------------------------------------------------
package gwwp_pkg;

  // Function codes of an input word.
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Character classes.
  localparam logic [1:0] CLS_ORDINARY = 2'd0;
  localparam logic [1:0] CLS_SPACE    = 2'd1;
  localparam logic [1:0] CLS_NEWLINE  = 2'd2;

  // Result kinds.
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_PAGE = 1'b1;

  // Layout phases.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_LAYOUT = 2'd2,
    PH_TAIL   = 2'd3
  } phase_e;

  // Configuration register indexes.
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_MAX_LINES  = 1'b1;

  localparam logic [15:0] LINE_WIDTH_RESET = 16'd320;
  localparam logic [5:0]  MAX_LINES_RESET  = 6'd11;
  localparam int          RES_DEPTH        = 4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_offset;
    logic [1:0]  char_class;
    logic [2:0]  char_bytes;
    logic [15:0] char_width;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] line_offset;
    logic [15:0] line_length;
    logic        line_blank;
    logic [31:0] page_first;
    logic [31:0] next_offset;
    logic        last;
  } out_word_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] position;
    logic [31:0] row_start;
    logic [16:0] row_width;
    logic [31:0] content_end;
    logic [31:0] break_space;
    logic [31:0] break_content_end;
    logic        space_seen;
    logic [16:0] width_after_space;
    logic [5:0]  rows_used;
    logic        prev_row_blank;
    logic        held_blank;
    logic [31:0] held_blank_offset;
    logic [31:0] first_offset;
  } lay_state_t;

  // Layout state plus the results gathered for one input word.
  typedef struct packed {
    lay_state_t                     s;
    out_word_t [RES_DEPTH-1:0]      rec;
    logic [2:0]                     n;
  } work_t;

endpackage

FILE: rtl/greedy_word_wrap_pager.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap_pager: greedy word wrap layout of one text page
// A start word opens a page at a byte offset, character words follow and an
// end word closes the text. The block returns line records and a page end
// record with the first laid out offset and the offset of the next page.
//
// Usage: the input channel carries one word per character (in_valid_i,
// in_stall_o, in_word_i). All layout decisions for a word are made in the
// cycle it is accepted; its results (zero to four) are written into a small
// result buffer and leave on the output channel (out_valid_o, out_stall_i,
// out_word_o) one per cycle while the receiver does not stall, the first
// in the cycle after acceptance. A word that causes one result or none
// streams at one word per cycle while the receiver does not stall; a word
// that causes more results holds the input while the buffer drains.
// The input is stalled while more than one result waits, or while the last
// one waits and the receiver stalls. Reset empties the buffer, returns the
// layout to idle and loads a line width of 320 pixels and 11 rows per page.
// Configuration goes through the APB port: line width at address 0, row
// count at address 4.
// ----------------------------------------------------------------------------
module greedy_word_wrap_pager
  import gwwp_pkg::*;
#(
  parameter int MAX_ROWS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o
);

  localparam logic [5:0] MaxRowsC = 6'(MAX_ROWS);

  logic [15:0] line_width_q;
  logic [5:0]  max_lines_q;
  lay_state_t  st_q;
  work_t       w_d;
  out_word_t [RES_DEPTH-1:0] rec_q;
  logic [2:0]  cnt_q;
  logic [1:0]  rd_q;
  logic        in_acc;
  logic        out_acc;
  logic        cfg_wr;
  logic [5:0]  row_lim;
  logic [15:0] width_lim;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_LINES) ? {26'd0, max_lines_q} : {16'd0, line_width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RESET;
      max_lines_q  <= MAX_LINES_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LINE_WIDTH) line_width_q <= pwdata[15:0];
      else max_lines_q <= pwdata[5:0];
    end
  end

  // Effective limits.
  always_comb begin
    row_lim = max_lines_q;
    if (row_lim == 6'd0) row_lim = 6'd1;
    if (row_lim > MaxRowsC) row_lim = MaxRowsC;
    width_lim = (line_width_q == 16'd0) ? 16'd1 : line_width_q;
  end

  function automatic work_t f_emit(work_t w, out_word_t r);
    work_t v;
    v = w;
    if (v.n < 3'(RES_DEPTH)) begin
      v.rec[v.n[1:0]] = r;
      v.n = v.n + 3'd1;
    end
    return v;
  endfunction

  function automatic work_t f_new_row(work_t w, logic [31:0] at);
    work_t v;
    v = w;
    v.s.row_start         = at;
    v.s.row_width         = '0;
    v.s.content_end       = at;
    v.s.space_seen        = 1'b0;
    v.s.width_after_space = '0;
    v.s.break_space       = at;
    v.s.break_content_end = at;
    return v;
  endfunction

  function automatic work_t f_page_end(work_t w, logic [31:0] nxt);
    work_t     v;
    out_word_t r;
    r = '0;
    r.kind        = KIND_PAGE;
    r.page_first  = w.s.first_offset;
    r.next_offset = nxt;
    v = f_emit(w, r);
    v.s.phase      = PH_IDLE;
    v.s.held_blank = 1'b0;
    return v;
  endfunction

  // Close the current row; the next row, if the page goes on, starts at nxt.
  function automatic work_t f_finish(work_t w, logic [31:0] line_end, logic [31:0] nxt,
                                     logic known, logic [5:0] lim);
    work_t       v;
    out_word_t   r;
    logic [31:0] len;
    v = w;
    r = '0;
    if (line_end == v.s.row_start) begin
      if (!v.s.prev_row_blank) begin
        v.s.held_blank        = 1'b1;
        v.s.held_blank_offset = v.s.row_start;
        v.s.prev_row_blank    = 1'b1;
        v.s.rows_used         = v.s.rows_used + 6'd1;
        if (v.s.rows_used >= lim) begin
          v.s.held_blank = 1'b0;
          if (known) begin
            v = f_page_end(v, nxt);
          end else begin
            v.s.phase    = PH_TAIL;
            v.s.position = nxt;
          end
          return v;
        end
      end
    end else begin
      len = line_end - v.s.row_start;
      if (v.s.held_blank) begin
        r.kind        = KIND_LINE;
        r.line_offset = v.s.held_blank_offset;
        r.line_blank  = 1'b1;
        v = f_emit(v, r);
        v.s.held_blank = 1'b0;
      end
      r = '0;
      r.line_offset = v.s.row_start;
      r.line_length = (len > 32'h0000_FFFF) ? 16'hFFFF : len[15:0];
      v = f_emit(v, r);
      v.s.rows_used      = v.s.rows_used + 6'd1;
      v.s.prev_row_blank = 1'b0;
      if (v.s.rows_used >= lim) begin
        v = f_page_end(v, nxt);
        return v;
      end
    end
    v = f_new_row(v, nxt);
    return v;
  endfunction

  // Place one character of a row, breaking at most twice.
  function automatic work_t f_layout(work_t w, logic [1:0] cls, logic [31:0] nb,
                                     logic [15:0] cw, logic [15:0] wl, logic [5:0] lim);
    work_t       v;
    logic        done;
    logic        first;
    logic [17:0] sum;
    logic [16:0] carried;
    v    = w;
    done = 1'b0;
    for (int p = 0; p < 3; p++) begin
      if (!done && v.s.phase == PH_LAYOUT) begin
        first = (v.s.position == v.s.row_start);
        sum   = {1'b0, v.s.row_width} + {2'b00, cw};
        if (cls == CLS_NEWLINE) begin
          v.s.position = v.s.position + nb;
          v = f_finish(v, v.s.content_end, v.s.position, 1'b0, lim);
          done = 1'b1;
        end else if (first || sum <= {2'b00, wl}) begin
          v.s.row_width = sum[16:0];
          if (cls == CLS_SPACE) begin
            if (!first) begin
              v.s.space_seen        = 1'b1;
              v.s.break_content_end = v.s.content_end;
              v.s.break_space       = v.s.position + nb;
              v.s.width_after_space = '0;
            end
          end else begin
            v.s.content_end       = v.s.position + nb;
            v.s.width_after_space = v.s.width_after_space + {1'b0, cw};
          end
          v.s.position = v.s.position + nb;
          done = 1'b1;
        end else if (cls == CLS_SPACE) begin
          v.s.position = v.s.position + nb;
          v = f_finish(v, v.s.content_end, v.s.position, 1'b0, lim);
          done = 1'b1;
        end else if (v.s.space_seen) begin
          carried = v.s.width_after_space;
          v = f_finish(v, v.s.break_content_end, v.s.break_space, 1'b1, lim);
          if (v.s.phase == PH_LAYOUT) begin
            v.s.row_width         = carried;
            v.s.width_after_space = carried;
            v.s.content_end       = v.s.position;
          end else begin
            done = 1'b1;
          end
        end else begin
          v = f_finish(v, v.s.content_end, v.s.position, 1'b1, lim);
        end
      end
    end
    return v;
  endfunction

  // Next layout state and results for the word at the input.
  always_comb begin
    logic [1:0]  cls;
    logic [31:0] nb;
    cls = (in_word_i.char_class == 2'd3) ? CLS_ORDINARY : in_word_i.char_class;
    nb  = (in_word_i.char_bytes == 3'd0) ? 32'd1 : {29'd0, in_word_i.char_bytes};
    w_d     = '0;
    w_d.s   = st_q;
    unique case (func_e'(in_word_i.func))
      FUNC_START: begin
        w_d.s.position     = in_word_i.start_offset;
        w_d.s.first_offset = in_word_i.start_offset;
        w_d = f_new_row(w_d, in_word_i.start_offset);
        w_d.s.rows_used         = '0;
        w_d.s.prev_row_blank    = 1'b0;
        w_d.s.held_blank        = 1'b0;
        w_d.s.held_blank_offset = '0;
        w_d.s.phase             = PH_LEAD;
      end
      FUNC_CHAR: begin
        unique case (st_q.phase)
          PH_LEAD: begin
            if (cls == CLS_ORDINARY) begin
              w_d.s.first_offset = st_q.position;
              w_d = f_new_row(w_d, st_q.position);
              w_d.s.phase = PH_LAYOUT;
              w_d = f_layout(w_d, cls, nb, in_word_i.char_width, width_lim, row_lim);
            end else begin
              w_d.s.position = st_q.position + nb;
            end
          end
          PH_LAYOUT: w_d = f_layout(w_d, cls, nb, in_word_i.char_width, width_lim, row_lim);
          PH_TAIL: begin
            if (cls == CLS_NEWLINE) w_d.s.position = st_q.position + nb;
            else w_d = f_page_end(w_d, st_q.position);
          end
          default: ;
        endcase
      end
      FUNC_END: begin
        unique case (st_q.phase)
          PH_LEAD: begin
            w_d.s.first_offset = st_q.position;
            w_d = f_page_end(w_d, st_q.position);
          end
          PH_LAYOUT: begin
            if (st_q.position != st_q.row_start)
              w_d = f_finish(w_d, st_q.content_end, st_q.position, 1'b1, row_lim);
            if (w_d.s.phase == PH_LAYOUT) w_d = f_page_end(w_d, st_q.position);
          end
          PH_TAIL: w_d = f_page_end(w_d, st_q.position);
          default: ;
        endcase
      end
      default: ;
    endcase
    if (w_d.n != 3'd0) w_d.rec[2'(w_d.n - 3'd1)].last = 1'b1;
  end

  // Handshakes.
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = rec_q[rd_q];
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (cnt_q > 3'd1) || ((cnt_q == 3'd1) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Layout state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_acc) begin
      st_q <= w_d.s;
    end
  end

  // Result buffer: loaded whole on an accepted word, drained one word a cycle while the receiver does not stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (in_acc) begin
      cnt_q <= w_d.n;
      rd_q  <= '0;
    end else if (out_acc) begin
      cnt_q <= cnt_q - 3'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) rec_q <= w_d.rec;
  end

  // The buffer never overflows its depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(RES_DEPTH))
    else $error("result count out of range");

  // Read pointer and count stay within the buffer.
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rd_q} + cnt_q) <= 3'(RES_DEPTH))
    else $error("read pointer past the buffer");

  // A word is only taken once the buffer is empty or emptying.
  a_acc_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && out_acc)))
    else $error("word accepted over pending results");

  // In the layout phase the row count stays below MAX_ROWS.
  a_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_LAYOUT |-> st_q.rows_used < MaxRowsC)
    else $error("row count past limit in layout");

endmodule
